/* design/dstq_pkg.sv */
// Package for the deadline sorted timer queue.
// Holds commands, widths, cell types and the sequencer state type.
package dstq_pkg;
	localparam int QueueDepthDef = 16;
	localparam int OwnerBitsDef = 8;
	localparam int TimeW = 64;
	localparam int OwnerW = 8;
	localparam int ActionW = 4;
	localparam int AlarmW = 32;
	localparam int CountW = 5;

	typedef enum logic [1:0] {
		CMD_SCHED_ABS = 2'd0,
		CMD_SCHED_REL = 2'd1,
		CMD_CANCEL    = 2'd2,
		CMD_SERVICE   = 2'd3
	} cmd_t;

	// Operation given to the cells; for a cancel each cell pops or holds by its position.
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2,
		OP_CANCEL = 2'd3
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CANCEL,
		ST_FIRE_NOW,
		ST_POP,
		ST_STATUS
	} state_t;
endpackage

/* design/deadline_sorted_timer_queue_top.sv */
// Top level of the deadline sorted timer queue.
// Depends on dstq_pkg and dstq_cell.
//
// Keeps up to QUEUE_DEPTH alarms sorted by 64-bit deadline in a chain of
// cells, the earliest in cell 0. An item is taken only while the block is
// idle. A schedule inserts (every cell compares its deadline with the new
// one and shifts right as needed), or fires at once when due or when the
// chain is full. A cancel walks the chain once, checking one cell per cycle
// and dropping a matching entry by shifting the tail left. Each due entry
// then pops from the head as one result, a pop waiting while the output is
// stalled; once the head is not due, a closing status item ends the
// sequence. The output register frees when the result is taken.
module deadline_sorted_timer_queue_top #(
	parameter int QUEUE_DEPTH = dstq_pkg::QueueDepthDef,
	parameter int OWNER_BITS  = dstq_pkg::OwnerBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    cmd,
	input  logic [dstq_pkg::TimeW-1:0]    deadline,
	input  logic [dstq_pkg::OwnerW-1:0]   owner_id,
	input  logic [dstq_pkg::ActionW-1:0]  action_id,
	input  logic [dstq_pkg::TimeW-1:0]    now_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          fired,
	output logic [dstq_pkg::OwnerW-1:0]   fired_owner,
	output logic [dstq_pkg::ActionW-1:0]  fired_action,
	output logic                          status,
	output logic [dstq_pkg::AlarmW-1:0]   alarm_low,
	output logic [dstq_pkg::CountW-1:0]   pending_count,
	output logic                          last
);
	import dstq_pkg::*;

	localparam int IdxW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;
	cell_op_t op;
	cell_op_t cancel_op;

	// held command
	logic [TimeW-1:0]      now_q;
	logic [TimeW-1:0]      dl_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [ActionW-1:0]    action_q;
	logic                  full_q;
	logic [CntW-1:0]       count_q;
	logic [IdxW-1:0]       scan_q;
	logic                  ins_q;

	// chain wires, index QUEUE_DEPTH is the empty slot past the tail
	logic                  c_valid [QUEUE_DEPTH+1];
	logic                  c_after [QUEUE_DEPTH+1];
	logic [TimeW-1:0]      c_dl    [QUEUE_DEPTH+1];
	logic [OWNER_BITS-1:0] c_own   [QUEUE_DEPTH+1];
	logic [ActionW-1:0]    c_act   [QUEUE_DEPTH+1];
	logic                  c_drop  [QUEUE_DEPTH];

	// output register
	logic                  ov_q;
	logic                  fired_q, status_q, last_q;
	logic [OWNER_BITS-1:0] fo_q;
	logic [ActionW-1:0]    fa_q;
	logic [AlarmW-1:0]     al_q;
	logic [CntW-1:0]       pc_q;
	logic                  out_free;

	logic [TimeW-1:0] in_dl;
	logic             head_due;
	logic             emit;

	assign out_free = !ov_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_dl = (cmd == CMD_SCHED_REL) ? now_time + deadline : deadline;
	assign head_due = c_valid[0] && (c_dl[0] <= now_q);

	assign c_valid[QUEUE_DEPTH] = 1'b0;
	assign c_after[QUEUE_DEPTH] = 1'b0;
	assign c_dl[QUEUE_DEPTH]    = '0;
	assign c_own[QUEUE_DEPTH]   = '0;
	assign c_act[QUEUE_DEPTH]   = '0;

	// Cancel: at scan position, drop the entry by shifting the tail left.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			c_drop[i] = (i >= int'(scan_q));
		end
	end

	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			cell_op_t      gop;
			logic          lv, la;
			logic [TimeW-1:0]      ld;
			logic [OWNER_BITS-1:0] lo;
			logic [ActionW-1:0]    lac;
			always_comb begin
				gop = op;
				if (op == OP_CANCEL) begin
					gop = c_drop[g] ? OP_POP : OP_HOLD;
				end
			end
			if (g == 0) begin : g_head
				assign lv = 1'b0;
				assign la = 1'b1;
				assign ld = '0;
				assign lo = '0;
				assign lac = '0;
			end else begin : g_body
				assign lv  = c_valid[g-1];
				assign la  = c_after[g-1];
				assign ld  = c_dl[g-1];
				assign lo  = c_own[g-1];
				assign lac = c_act[g-1];
			end
			dstq_cell #(.OWNER_BITS(OWNER_BITS)) u_cell (
				.clk            (clk),
				.arst_n         (arst_n),
				.op             (gop),
				.new_deadline   (dl_q),
				.new_owner      (owner_q),
				.new_action     (action_q),
				.left_valid     (lv),
				.left_goes_after(la),
				.left_deadline  (ld),
				.left_owner     (lo),
				.left_action    (lac),
				.right_valid    (c_valid[g+1]),
				.right_deadline (c_dl[g+1]),
				.right_owner    (c_own[g+1]),
				.right_action   (c_act[g+1]),
				.valid          (c_valid[g]),
				.goes_after     (c_after[g]),
				.deadline       (c_dl[g]),
				.owner          (c_own[g]),
				.action         (c_act[g])
			);
		end
	endgenerate

	// Entry at scan position matches the owner to cancel.
	logic scan_hit;
	logic scan_valid;
	assign scan_valid = c_valid[scan_q];
	assign scan_hit = scan_valid && (c_own[scan_q] == owner_q);
	assign cancel_op = scan_hit ? OP_CANCEL : OP_HOLD;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_CANCEL) begin
						state_d = ST_CANCEL;
					end else if (cmd == CMD_SERVICE) begin
						state_d = ST_POP;
					end else if (in_dl <= now_time || count_q == CntW'(QUEUE_DEPTH)) begin
						state_d = ST_FIRE_NOW;
					end else begin
						state_d = ST_POP;
					end
				end
			end
			ST_CANCEL: begin
				if (!scan_valid || (!scan_hit && scan_q == IdxW'(QUEUE_DEPTH - 1))) begin
					state_d = ST_POP;
				end
			end
			ST_FIRE_NOW: if (out_free) state_d = ST_POP;
			// hold while the insert lands, then leave once the head is not due
			ST_POP: if (!ins_q && out_free && !head_due) state_d = ST_STATUS;
			ST_STATUS: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// cell operation and result emission
	always_comb begin
		op = OP_HOLD;
		emit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// insert happens in the next cycle from held fields
			end
			ST_CANCEL: op = cancel_op;
			ST_FIRE_NOW: emit = out_free;
			ST_POP: begin
				if (!ins_q && out_free && head_due) begin
					emit = 1'b1;
					op = OP_POP;
				end
			end
			ST_STATUS: emit = out_free;
			default: op = OP_HOLD;
		endcase
		if (ins_q) op = OP_INSERT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			ov_q    <= 1'b0;
			ins_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ins_q   <= 1'b0;
			if (state_q == ST_IDLE && in_valid) begin
				scan_q <= '0;
				if ((cmd == CMD_SCHED_ABS || cmd == CMD_SCHED_REL) && !(in_dl <= now_time)
						&& count_q != CntW'(QUEUE_DEPTH)) begin
					ins_q <= 1'b1;
				end
			end
			if (op == OP_INSERT) count_q <= count_q + 1'b1;
			if (op == OP_POP) count_q <= count_q - 1'b1;
			if (state_q == ST_CANCEL) begin
				if (scan_hit) count_q <= count_q - 1'b1;
				else scan_q <= scan_q + 1'b1;
			end
			if (emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// hold the command fields; insert waits on ins_q so POP sees the update
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			now_q    <= now_time;
			dl_q     <= in_dl;
			owner_q  <= owner_id[OWNER_BITS-1:0];
			action_q <= action_id;
			full_q   <= (cmd == CMD_SCHED_ABS || cmd == CMD_SCHED_REL)
				&& !(in_dl <= now_time) && count_q == CntW'(QUEUE_DEPTH);
		end
		if (emit) begin
			fired_q  <= 1'b0;
			fo_q     <= '0;
			fa_q     <= '0;
			status_q <= 1'b0;
			al_q     <= '0;
			pc_q     <= '0;
			last_q   <= 1'b0;
			case (state_q)
				ST_FIRE_NOW: begin
					fired_q  <= 1'b1;
					fo_q     <= owner_q;
					fa_q     <= action_q;
					status_q <= full_q;
				end
				ST_POP: begin
					fired_q <= 1'b1;
					fo_q    <= c_own[0];
					fa_q    <= c_act[0];
				end
				default: begin
					status_q <= full_q;
					al_q     <= c_valid[0] ? c_dl[0][AlarmW-1:0] : '0;
					pc_q     <= count_q;
					last_q   <= 1'b1;
				end
			endcase
		end
	end

	// A pop cycle with nothing due emits nothing: suppress by state.
	assign out_valid     = ov_q;
	assign fired         = fired_q;
	assign fired_owner   = OwnerW'(fo_q);
	assign fired_action  = fa_q;
	assign status        = status_q;
	assign alarm_low     = al_q;
	assign pending_count = CountW'(pc_q);
	assign last          = last_q;
endmodule

/* design/dstq_cell.sv */
// One cell of the sorted chain: holds one entry and its valid bit.
// Depends on dstq_pkg.
module dstq_cell #(
	parameter int OWNER_BITS = dstq_pkg::OwnerBitsDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dstq_pkg::cell_op_t          op,
	input  logic [dstq_pkg::TimeW-1:0]  new_deadline,
	input  logic [OWNER_BITS-1:0]       new_owner,
	input  logic [dstq_pkg::ActionW-1:0] new_action,
	// left neighbor (toward head)
	input  logic                        left_valid,
	input  logic                        left_goes_after,
	input  logic [dstq_pkg::TimeW-1:0]  left_deadline,
	input  logic [OWNER_BITS-1:0]       left_owner,
	input  logic [dstq_pkg::ActionW-1:0] left_action,
	// right neighbor (toward tail)
	input  logic                        right_valid,
	input  logic [dstq_pkg::TimeW-1:0]  right_deadline,
	input  logic [OWNER_BITS-1:0]       right_owner,
	input  logic [dstq_pkg::ActionW-1:0] right_action,
	output logic                        valid,
	output logic                        goes_after,
	output logic [dstq_pkg::TimeW-1:0]  deadline,
	output logic [OWNER_BITS-1:0]       owner,
	output logic [dstq_pkg::ActionW-1:0] action
);
	import dstq_pkg::*;

	logic valid_q;
	logic [TimeW-1:0] deadline_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [ActionW-1:0] action_q;
	logic own_after;

	// New entry lands after this cell when this entry is strictly earlier.
	assign own_after = valid_q && (deadline_q < new_deadline);
	assign goes_after = own_after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				OP_INSERT: valid_q <= valid_q | left_valid | !left_valid & left_goes_after;
				OP_POP:    valid_q <= right_valid;
				default:   valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_INSERT: begin
				if (!own_after) begin
					if (left_goes_after) begin
						deadline_q <= new_deadline;
						owner_q    <= new_owner;
						action_q   <= new_action;
					end else begin
						deadline_q <= left_deadline;
						owner_q    <= left_owner;
						action_q   <= left_action;
					end
				end
			end
			OP_POP: begin
				deadline_q <= right_deadline;
				owner_q    <= right_owner;
				action_q   <= right_action;
			end
			default: begin
			end
		endcase
	end

	assign valid    = valid_q;
	assign deadline = deadline_q;
	assign owner    = owner_q;
	assign action   = action_q;
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the deadline sorted timer queue: directed table, then random items.
// Depends on dstq_pkg and deadline_sorted_timer_queue_top.
module tb_top;
	import dstq_pkg::*;

	localparam int Depth = QueueDepthDef;
	localparam int RandItems = 195;

	// one expected result item
	typedef struct packed {
		logic                fired;
		logic [OwnerW-1:0]   owner;
		logic [ActionW-1:0]  action;
		logic                status;
		logic [AlarmW-1:0]   alarm;
		logic [CountW-1:0]   count;
		logic                last;
	} alarm_res_t;

	// one directed row; chk set means its typed-in first result is checked against the prediction
	typedef struct {
		cmd_t               c;
		logic [TimeW-1:0]   dl;
		logic [OwnerW-1:0]  own;
		logic [ActionW-1:0] act;
		logic [TimeW-1:0]   now;
		bit                 chk;
		alarm_res_t         want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = '0;
	logic [TimeW-1:0] deadline = '0;
	logic [OwnerW-1:0] owner_id = '0;
	logic [ActionW-1:0] action_id = '0;
	logic [TimeW-1:0] now_time = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic fired, status, last;
	logic [OwnerW-1:0] fired_owner;
	logic [ActionW-1:0] fired_action;
	logic [AlarmW-1:0] alarm_low;
	logic [CountW-1:0] pending_count;

	// predictor copy of the alarm table
	logic [TimeW-1:0]   tbl_dl [Depth];
	logic [OwnerW-1:0]  tbl_own [Depth];
	logic [ActionW-1:0] tbl_act [Depth];
	int tbl_cnt = 0;

	alarm_res_t pending_results [$];
	int first_new = 0;
	int mismatches = 0;
	int hold_cycles = 0;
	logic [TimeW-1:0] clock_now = 64'd1000;

	deadline_sorted_timer_queue_top u_top (.*);

	always #1 clk = ~clk;

	function automatic alarm_res_t fire_res(logic [OwnerW-1:0] o, logic [ActionW-1:0] a,
			logic s);
		alarm_res_t r;
		r = '0;
		r.fired = 1'b1;
		r.owner = o;
		r.action = a;
		r.status = s;
		return r;
	endfunction

	function automatic void drop_entry(int pos);
		for (int i = pos; i < tbl_cnt - 1; i++) begin
			tbl_dl[i] = tbl_dl[i+1];
			tbl_own[i] = tbl_own[i+1];
			tbl_act[i] = tbl_act[i+1];
		end
		tbl_cnt--;
	endfunction

	// Work out every result of one command and advance the table.
	function automatic void predict_alarms(cmd_t c, logic [TimeW-1:0] dl,
			logic [OwnerW-1:0] own, logic [ActionW-1:0] act, logic [TimeW-1:0] now);
		logic full_st;
		int pos;
		int i;
		alarm_res_t st;
		full_st = 1'b0;
		first_new = pending_results.size();
		if (c == CMD_SCHED_ABS || c == CMD_SCHED_REL) begin
			if (c == CMD_SCHED_REL)
				dl = now + dl;
			if (dl <= now) begin
				pending_results.push_back(fire_res(own, act, 1'b0));
			end else if (tbl_cnt >= Depth) begin
				full_st = 1'b1;
				pending_results.push_back(fire_res(own, act, 1'b1));
			end else begin
				pos = 0;
				while (pos < tbl_cnt && tbl_dl[pos] < dl)
					pos++;
				for (i = tbl_cnt; i > pos; i--) begin
					tbl_dl[i] = tbl_dl[i-1];
					tbl_own[i] = tbl_own[i-1];
					tbl_act[i] = tbl_act[i-1];
				end
				tbl_dl[pos] = dl;
				tbl_own[pos] = own;
				tbl_act[pos] = act;
				tbl_cnt++;
			end
		end else if (c == CMD_CANCEL) begin
			i = 0;
			while (i < tbl_cnt) begin
				if (tbl_own[i] == own)
					drop_entry(i);
				else
					i++;
			end
		end
		while (tbl_cnt > 0 && tbl_dl[0] <= now) begin
			pending_results.push_back(fire_res(tbl_own[0], tbl_act[0], 1'b0));
			drop_entry(0);
		end
		st = '0;
		st.status = full_st;
		st.alarm = tbl_cnt > 0 ? tbl_dl[0][AlarmW-1:0] : '0;
		st.count = CountW'(tbl_cnt);
		st.last = 1'b1;
		pending_results.push_back(st);
	endfunction

	// Offer one item, hold it until taken, then predict.
	task automatic offer_item(cmd_t c, logic [TimeW-1:0] dl, logic [OwnerW-1:0] own,
			logic [ActionW-1:0] act, logic [TimeW-1:0] now);
		in_valid <= 1'b1;
		cmd <= c;
		deadline <= dl;
		owner_id <= own;
		action_id <= act;
		now_time <= now;
		do @(posedge clk); while (!in_ready);
		predict_alarms(c, dl, own, act, now);
	endtask

	// A zero gap keeps the burst going.
	task automatic idle_input(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		alarm_res_t got, exp_r;
		if (arst_n && out_valid && out_ready) begin
			got = '{fired, fired_owner, fired_action, status, alarm_low, pending_count, last};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				exp_r = pending_results.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", exp_r, got);
				end
			end
		end
	end

	// Receiver: own stall pattern, plus one long hold-off when asked.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 7))
				0, 1: out_ready <= 1'b0;
				default: out_ready <= 1'b1;
			endcase
		end
	end

	// Check the first result of directed rows whose result is known at a glance.
	task automatic run_row(row_t r);
		offer_item(r.c, r.dl, r.own, r.act, r.now);
		if (r.chk && pending_results[first_new] !== r.want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row: expected %p predicted %p", r.want,
					pending_results[first_new]);
		end
	endtask

	initial begin
		row_t rows [$];
		row_t r;
		cmd_t c;
		logic [TimeW-1:0] dl;
		int burst;
		int k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// service on an empty table: just the status item
		r = '{CMD_SERVICE, 64'd0, 8'd0, 4'd0, 64'd0, 1'b1, '0};
		r.want.last = 1'b1;
		rows.push_back(r);
		// due deadline fires at once, extremes of owner and action
		r = '{CMD_SCHED_ABS, 64'd5, 8'hFF, 4'hF, 64'd5, 1'b1, '0};
		r.want = fire_res(8'hFF, 4'hF, 1'b0);
		rows.push_back(r);
		// relative offset wrapping past 2^64 is due at once
		r = '{CMD_SCHED_REL, '1, 8'h00, 4'h0, 64'd10, 1'b1, '0};
		r.want = fire_res(8'h00, 4'h0, 1'b0);
		rows.push_back(r);
		// maximum absolute deadline stored
		r = '{CMD_SCHED_ABS, '1, 8'hA5, 4'h5, 64'd0, 1'b1, '0};
		r.want.alarm = '1;
		r.want.count = 5'd1;
		r.want.last = 1'b1;
		rows.push_back(r);
		// equal deadlines, then fill the table
		for (int i = 0; i < 15; i++)
			rows.push_back('{CMD_SCHED_ABS, 64'd100 + 64'(i % 3), 8'(i % 4), 4'(i), 64'd0,
				1'b0, '0});
		// table full: fires with status 1
		r = '{CMD_SCHED_ABS, 64'd50, 8'h5A, 4'hA, 64'd0, 1'b1, '0};
		r.want = fire_res(8'h5A, 4'hA, 1'b1);
		rows.push_back(r);
		rows.push_back('{CMD_CANCEL, 64'd0, 8'd1, 4'd0, 64'd0, 1'b0, '0});
		rows.push_back('{CMD_CANCEL, 64'd0, 8'd77, 4'd0, 64'd0, 1'b0, '0});
		rows.push_back('{CMD_SCHED_REL, 64'd3, 8'd9, 4'd3, 64'd99, 1'b0, '0});
		rows.push_back('{CMD_SERVICE, '1, 8'hFF, 4'hF, 64'd101, 1'b0, '0});
		rows.push_back('{CMD_SERVICE, 64'd0, 8'd0, 4'd0, '1, 1'b0, '0});
		foreach (rows[i]) begin
			run_row(rows[i]);
			if ($urandom_range(0, 2) == 0)
				idle_input($urandom_range(1, 4));
		end
		wait_drained();

		// random part: mostly near-future deadlines on a moving clock
		k = 0;
		while (k < RandItems) begin
			if (k == 60)
				hold_cycles <= 300;
			if (k == 120)
				wait_drained();
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && k < RandItems; b++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: c = CMD_SCHED_ABS;
					4, 5: c = CMD_SCHED_REL;
					6, 7: c = CMD_CANCEL;
					default: c = CMD_SERVICE;
				endcase
				if ($urandom_range(0, 9) == 0)
					dl = {$urandom, $urandom};
				else if (c == CMD_SCHED_REL)
					dl = 64'($urandom_range(0, 60));
				else
					dl = clock_now + 64'($urandom_range(0, 80)) - 64'd10;
				if ($urandom_range(0, 40) == 0)
					clock_now = {$urandom, $urandom};
				else
					clock_now = clock_now + 64'($urandom_range(0, 12));
				offer_item(c, dl, 8'($urandom_range(0, 255)) & ($urandom_range(0, 1) ? 8'h07 : 8'hFF),
					4'($urandom_range(0, 15)), clock_now);
				k++;
			end
			idle_input($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
		end
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Safety limit well beyond the slowest correct run.
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end
endmodule
